@@ src/lzsd_pkg.sv @@
// Shared types and constants for the LZSS stream decoder.
// No dependencies; imported by lzsd_ring and lzss_stream_decoder_core.
package lzsd_pkg;

	localparam int unsigned RING_DEPTH_DEF = 4096;
	localparam int unsigned MAX_COPY_DEF   = 18;
	localparam int unsigned MIN_MATCH      = 3;
	localparam logic [7:0]  SPACE_BYTE     = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_stream;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        last_of_run;
		logic [31:0] produced_count;
	} out_item_t;

	// control from the sequencer to the history ring
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clr;
	} ring_ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_COPY
	} dec_state_t;

endpackage

@@ src/lzsd_ring.sv @@
// History ring: single-port-write, registered-read byte memory with fill tracking.
// Depends on lzsd_pkg. Entries not written since the last clear read as spaces; same-cycle writes forward.
module lzsd_ring #(
	parameter int unsigned RING_DEPTH = lzsd_pkg::RING_DEPTH_DEF,
	parameter int unsigned MAX_COPY   = lzsd_pkg::MAX_COPY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lzsd_pkg::ring_ctl_t           ctl,
	input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
	input  logic [7:0]                    wr_data,
	output logic [7:0]                    rd_data
);
	import lzsd_pkg::*;

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam logic [AW-1:0] START = AW'(RING_DEPTH - MAX_COPY);
	localparam logic [AW:0]   FULL  = (AW+1)'(RING_DEPTH);

	logic [7:0]    mem [RING_DEPTH];
	logic [AW-1:0] wp_q;
	logic [AW:0]   fill_q;
	logic [7:0]    mem_s1;
	logic [7:0]    fwd_data_s1;
	logic          fwd_s1;
	logic          written_s1;
	logic [AW-1:0] offset;
	logic          written;
	logic          fwd;

	// entries are written in pointer order from START, so a fill count tells
	// which ones hold real data
	assign offset  = rd_addr - START;
	assign written = fill_q > {1'b0, offset};
	assign fwd     = ctl.wr_en && (rd_addr == wp_q);

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wp_q] <= wr_data;
		end
		if (ctl.rd_en) begin
			mem_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			fwd_s1      <= fwd;
			fwd_data_s1 <= wr_data;
			written_s1  <= written;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= START;
			fill_q <= '0;
		end else if (ctl.clr) begin
			wp_q   <= START;
			fill_q <= '0;
		end else if (ctl.wr_en) begin
			wp_q <= wp_q + AW'(1);
			if (fill_q != FULL) begin
				fill_q <= fill_q + (AW+1)'(1);
			end
		end
	end

	assign rd_data = fwd_s1 ? fwd_data_s1 : (written_s1 ? mem_s1 : SPACE_BYTE);

endmodule

@@ src/lzss_stream_decoder_core.sv @@
// LZSS stream decoder top level; depends on lzsd_pkg and lzsd_ring.
// Literal: via the emit stage to the output register; no item is accepted while a byte waits.
// Pair: after the 2nd byte the ring is read (3..18 reads) once per cycle unless output stalls;
// bytes go via the ring read register and emit stage to the output register, and no item is
// accepted until the copy ends and the emit stage is empty. Reset and end of stream rewind the
// ring by clearing its fill count, no sweep; arst_n clears all control state asynchronously.
module lzss_stream_decoder_core #(
	parameter int unsigned RING_DEPTH = lzsd_pkg::RING_DEPTH_DEF,
	parameter int unsigned MAX_COPY   = lzsd_pkg::MAX_COPY_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lzsd_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output lzsd_pkg::out_item_t out_item
);
	import lzsd_pkg::*;

	localparam int unsigned AW = $clog2(RING_DEPTH);
	localparam int unsigned CW = $clog2(MAX_COPY + 1);

	dec_state_t    state_q, state_d;
	logic [8:0]    flag_q;
	logic          phase_q;
	logic [7:0]    held_q;
	logic [AW-1:0] pos_q;
	logic [CW-1:0] cnt_q;
	logic          eos_q;
	logic          s1_valid_q;
	logic          lit_s1, last_s1, eos_s1;
	logic [7:0]    lit_byte_s1;
	logic          out_valid_q;
	out_item_t     out_q;
	logic [31:0]   total_q;

	logic          in_fire, out_free, emit, issue;
	logic          take_lit, clr_accept;
	logic [7:0]    emit_byte, ring_data;
	logic [31:0]   total_next;
	ring_ctl_t     ring_ctl;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = s1_valid_q && out_free;

	assign take_lit   = in_fire && !phase_q && (flag_q > 9'd1) && flag_q[0];
	// items that produce nothing rewind the ring at once on end of stream
	assign clr_accept = in_fire && in_item.end_of_stream && !phase_q && !take_lit;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && phase_q) begin
					state_d = ST_COPY;
				end
			end
			ST_COPY: begin
				if (issue && cnt_q == CW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		issue    = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = !s1_valid_q;
			ST_COPY: issue    = !s1_valid_q || out_free;
			default: begin
				in_ready = 1'b0;
				issue    = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q  <= '0;
			phase_q <= 1'b0;
			held_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			eos_q   <= 1'b0;
		end else begin
			if (in_fire) begin
				if (phase_q) begin
					pos_q <= AW'({in_item.in_byte[7:4], held_q});
					cnt_q <= CW'(in_item.in_byte[3:0]) + CW'(MIN_MATCH);
					eos_q <= in_item.end_of_stream;
				end
				if (in_item.end_of_stream) begin
					flag_q  <= '0;
					phase_q <= 1'b0;
				end else if (phase_q) begin
					phase_q <= 1'b0;
					flag_q  <= flag_q >> 1;
				end else if (flag_q <= 9'd1) begin
					flag_q <= {1'b1, in_item.in_byte};
				end else if (flag_q[0]) begin
					flag_q <= flag_q >> 1;
				end else begin
					held_q  <= in_item.in_byte;
					phase_q <= 1'b1;
				end
			end else if (issue) begin
				pos_q <= pos_q + AW'(1);
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// emit stage: one byte waiting for the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (take_lit || issue) begin
			s1_valid_q <= 1'b1;
		end else if (emit) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_lit) begin
			lit_s1      <= 1'b1;
			lit_byte_s1 <= in_item.in_byte;
			last_s1     <= 1'b1;
			eos_s1      <= in_item.end_of_stream;
		end else if (issue) begin
			lit_s1  <= 1'b0;
			last_s1 <= (cnt_q == CW'(1));
			eos_s1  <= eos_q && (cnt_q == CW'(1));
		end
	end

	assign ring_ctl.rd_en = issue;
	assign ring_ctl.wr_en = emit;
	assign ring_ctl.clr   = (emit && eos_s1) || clr_accept;

	lzsd_ring #(
		.RING_DEPTH (RING_DEPTH),
		.MAX_COPY   (MAX_COPY)
	) u_ring (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ring_ctl),
		.rd_addr (pos_q),
		.wr_data (emit_byte),
		.rd_data (ring_data)
	);

	assign emit_byte  = lit_s1 ? lit_byte_s1 : ring_data;
	assign total_next = (total_q == 32'hFFFF_FFFF) ? total_q : total_q + 32'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				total_q     <= eos_s1 ? '0 : total_next;
				out_valid_q <= 1'b1;
			end else begin
				if (clr_accept) begin
					total_q <= '0;
				end
				if (out_ready) begin
					out_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte       <= emit_byte;
			out_q.last_of_run    <= last_s1;
			out_q.produced_count <= total_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// a copy always has bytes left and never overlaps a half-read pair
	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COPY |-> cnt_q != '0 && !phase_q)
		else $error("copy state with empty count or pending pair");

	// a waiting byte is never dropped while the output is blocked
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !out_free |=> s1_valid_q)
		else $error("emit stage lost a byte");

	// every emitted byte lands in the output register
	a_emit_out: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("emitted byte not presented");

endmodule
